// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file rht_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rht_pkg.sv -----
package rht_pkg;

    // Fixed field widths
    localparam int KEY_W       = 64;
    localparam int IN_HANDLE_W = 16;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 10;
    localparam int PROBE_W     = 11;
    localparam int MASK_W      = 10;
    localparam int SHIFT_W     = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 1;

    // Operation codes
    typedef logic [1:0] rht_op_t;
    localparam rht_op_t OP_LOOKUP = 2'd0;
    localparam rht_op_t OP_INSERT = 2'd1;
    localparam rht_op_t OP_CLEAR  = 2'd2;
    localparam rht_op_t OP_NOP    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Config register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SHIFT = 1'b1;
    localparam logic [MASK_W-1:0]    SLOT_MASK_RST  = 10'd1023;
    localparam logic [SHIFT_W-1:0]   HASH_SHIFT_RST = 3'd3;

    typedef struct packed {
        rht_op_t                  op;
        logic [KEY_W-1:0]         return_key;
        logic [IN_HANDLE_W-1:0]   descriptor_handle;
    } rht_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [IN_HANDLE_W-1:0]   found_handle;
        logic [SLOT_IDX_W-1:0]    slot_index;
        logic [PROBE_W-1:0]       probe_count;
    } rht_result_t;

endpackage

// ----- rtl/core/rht_slot_mem.sv -----
module rht_slot_mem
    import rht_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 81
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    // Slot storage: {valid, key, handle} per slot
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/rht_probe_ctrl.sv -----
module rht_probe_ctrl
    import rht_pkg::*;
#(
    parameter int SLOTS       = 1024,
    parameter int HANDLE_BITS = 16,
    localparam int IW         = $clog2(SLOTS),
    localparam int WORD_W     = 1 + KEY_W + HANDLE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rht_item_t          item,
    input  logic [MASK_W-1:0]  slot_mask,
    input  logic [SHIFT_W-1:0] hash_shift,
    output logic               busy,
    output logic               done,
    output rht_result_t        result,
    output logic               mem_rd_en,
    output logic [IW-1:0]      mem_rd_addr,
    input  logic [WORD_W-1:0]  mem_rd_data,
    output logic               mem_wr_en,
    output logic [IW-1:0]      mem_wr_addr,
    output logic [WORD_W-1:0]  mem_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    state_t                 state_reg, state_next;
    logic [IW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                   clr_report_reg, clr_report_next;
    logic                   done_reg, done_next;
    rht_result_t            result_reg, result_next;
    rht_op_t                op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [IW-1:0]          mask_reg, mask_next;
    logic [IW-1:0]          cur_idx_reg, cur_idx_next;
    logic [PROBE_W-1:0]     probe_n_reg, probe_n_next;

    logic [IW-1:0]          mask_w;
    logic [IW-1:0]          home;
    logic [IW-1:0]          step_idx;
    logic [PROBE_W-1:0]     sweep;
    logic                   rd_valid;
    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;

    // Effective mask and home slot of the incoming key
    assign mask_w = IW'(32'(slot_mask) & (SLOTS - 1));
    assign home   = IW'(item.return_key >> hash_shift) & mask_w;

    // Probe walk helpers
    assign step_idx = (cur_idx_reg + IW'(1)) & mask_reg;
    assign sweep    = PROBE_W'(mask_reg) + PROBE_W'(1);

    // Slot word fields
    assign rd_valid  = mem_rd_data[WORD_W-1];
    assign rd_key    = mem_rd_data[WORD_W-2 -: KEY_W];
    assign rd_handle = mem_rd_data[HANDLE_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        mask_next       = mask_reg;
        cur_idx_next    = cur_idx_reg;
        probe_n_next    = probe_n_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = home;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_idx_reg;
        mem_wr_data     = {1'b1, key_reg, handle_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = item.op;
                    key_next    = item.return_key;
                    handle_next = HANDLE_BITS'(item.descriptor_handle);
                    case (item.op)
                        OP_LOOKUP, OP_INSERT:
                        begin
                            // read home slot now, evaluate next cycle
                            mem_rd_en    = 1'b1;
                            mem_rd_addr  = home;
                            mask_next    = mask_w;
                            cur_idx_next = home;
                            probe_n_next = PROBE_W'(1);
                            state_next   = S_PROBE;
                        end
                        OP_CLEAR:
                        begin
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end

            S_PROBE:
            begin
                // fetch the following slot speculatively; dropped if the walk ends
                mem_rd_en   = 1'b1;
                mem_rd_addr = step_idx;
                result_next = '0;
                if (!rd_valid)
                begin
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                    result_next.probe_count = probe_n_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        mem_wr_en              = 1'b1;
                        result_next.status     = ST_OK;
                        result_next.slot_index = SLOT_IDX_W'(cur_idx_reg);
                    end
                    else
                    begin
                        result_next.status = ST_MISS;
                    end
                end
                else if (op_reg == OP_LOOKUP && rd_key == key_reg)
                begin
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                    result_next.status       = ST_OK;
                    result_next.found_handle = IN_HANDLE_W'(rd_handle);
                    result_next.slot_index   = SLOT_IDX_W'(cur_idx_reg);
                    result_next.probe_count  = probe_n_reg;
                end
                else if (probe_n_reg == sweep)
                begin
                    // whole sweep done without a stop
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                    result_next.status      = (op_reg == OP_INSERT) ? ST_FULL : ST_MISS;
                    result_next.probe_count = sweep;
                end
                else
                begin
                    result_next  = result_reg;
                    cur_idx_next = step_idx;
                    probe_n_next = probe_n_reg + PROBE_W'(1);
                end
            end

            S_CLEAR:
            begin
                // drop one valid bit per cycle
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                mem_wr_data = '0;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next      = S_IDLE;
                    clr_report_next = 1'b0;
                    if (clr_report_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts a silent clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
        end
    end

    // Item payload and probe position
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        mask_reg    <= mask_next;
        cur_idx_reg <= cur_idx_next;
        probe_n_reg <= probe_n_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/return_address_hash_table_unit.sv -----
// Return-address hash table: open addressing with linear probing over one
// single-port-read slot memory. An item is taken when start is high and busy
// is low; its result appears for exactly one cycle with done, and the
// receiver cannot stall it. Lookup and insert probe 1 to slot_mask + 1
// slots (slot_mask being ANDed with SLOTS - 1): the memory's registered
// read delivers one slot per cycle, the next slot being fetched while the
// current one is compared. Items do not overlap: the next one is taken
// only once busy falls. Clear walks all SLOTS entries, one per cycle, and
// then raises done. After reset the same clearing pass runs with busy high
// and no result; config writes are taken at any time but should only be
// made while the block is idle.
module return_address_hash_table_unit
    import rht_pkg::*;
#(
    parameter int SLOTS       = 1024,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rht_item_t             item,
    output logic                  done,
    output rht_result_t           result,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW     = $clog2(SLOTS);
    localparam int WORD_W = 1 + KEY_W + HANDLE_BITS;

    logic [MASK_W-1:0]  slot_mask_reg;
    logic [SHIFT_W-1:0] hash_shift_reg;

    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [WORD_W-1:0]  mem_rd_data;
    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg  <= SLOT_MASK_RST;
            hash_shift_reg <= HASH_SHIFT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_SLOT_MASK:  slot_mask_reg  <= cfg_data;
                CFG_HASH_SHIFT: hash_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Probe sequencer
    rht_probe_ctrl #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .slot_mask   (slot_mask_reg),
        .hash_shift  (hash_shift_reg),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // Slot memory
    rht_slot_mem #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule

// ----- rtl/core/rht_checker.sv -----
`include "assert_macros.svh"

module rht_checker
    import rht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input rht_result_t result
);

    logic fail_clean;
    logic status_known;

    // Field checks on the result bus
    assign fail_clean   = (result.found_handle == '0) && (result.slot_index == '0) &&
                          (result.probe_count != '0);
    assign status_known = (result.status == ST_OK) || (result.status == ST_MISS) ||
                          (result.status == ST_FULL);

    // A result only shows while the block is idle again
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "done while busy")

    // No result without an accepted item or ongoing work
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !busy && !start, !done, "result from nowhere")

    // An accepted item either finishes at once or keeps the block busy
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy || done, "item dropped")

    // Failed operations carry no handle and no slot, but a nonzero probe count
    `ASSERT_SAME(a_fail_fields, clk, rst_n, done && (result.status != ST_OK), fail_clean, "bad fail fields")

    // Status stays within its codes
    `ASSERT_SAME(a_status_code, clk, rst_n, done, status_known, "bad status")

endmodule

bind return_address_hash_table_unit rht_checker u_rht_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
